>>> hw/rtl/drt_pkg.sv
// shared types, constants and codes of the device registry table
package drt_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int PTR_W = $clog2(TABLE_SLOTS + 1);
   localparam int ENTRY_W = 32;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_NTH = 3'd3;
   localparam logic [2:0] OP_COUNT = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [7:0] NEW_STATUS = 8'h80;
   localparam logic [7:0] NOT_FOUND_TYPE = 8'hff;
   localparam int COUNT_MAX = 127;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] dev_addr;
      logic [7:0]  dev_type;
      logic [5:0]  nth_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_type;
      logic [7:0]  found_state;
      logic [15:0] found_addr;
      logic [6:0]  type_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  dtype;
      logic [7:0]  state;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       issue;
      logic       shift_wr;
      logic       start_shift;
      logic       capture;
      logic       append;
      logic       shrink;
      logic       clear;
      logic       rsp_load;
      logic [1:0] status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       addr_zero;
      logic       full;
      logic       hit;
      logic       scan_end;
   } dp_stat_type;

endpackage

>>> hw/rtl/drt_ram.sv
// generic single-port-write ram with registered read
module drt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/drt_datapath.sv
// table storage, scan pointers, match logic and result register
module drt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  drt_pkg::req_type     req_data,
   input  drt_pkg::dp_cmd_type  cmd,
   output drt_pkg::dp_stat_type stat,
   output drt_pkg::rsp_type     rsp_data
);
   import drt_pkg::*;

   req_type            item_ff;
   logic [PTR_W-1:0]   used_ff, used_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic [PTR_W-1:0]   cnt_ff, cnt_in;
   entry_type          cap_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               rd_go;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic               addr_match;
   logic               type_match;
   logic               rank_match;

   assign rd_go = cmd.issue && (rd_ptr_ff < used_ff);

   assign wr_en = cmd.append || (cmd.shift_wr && rd_vld_ff);
   assign wr_addr = cmd.append ? used_ff[SLOT_W-1:0] : rd_idx_ff - SLOT_W'(1);
   always_comb begin
      if (cmd.append) begin
         wr_entry.addr = item_ff.dev_addr;
         wr_entry.dtype = item_ff.dev_type;
         wr_entry.state = NEW_STATUS;
      end else begin
         wr_entry = rd_entry;
      end
   end

   drt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_go),
      .rd_addr (rd_ptr_ff[SLOT_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   assign addr_match = (rd_entry.addr == item_ff.dev_addr) && (item_ff.dev_addr != 16'd0);
   assign type_match = (rd_entry.dtype == item_ff.dev_type);
   assign rank_match = (32'(cnt_ff) == 32'(item_ff.nth_index));

   always_comb begin
      stat.op = item_ff.op;
      stat.addr_zero = (item_ff.dev_addr == 16'd0);
      stat.full = (used_ff >= PTR_W'(TABLE_SLOTS));
      stat.hit = rd_vld_ff && ((item_ff.op == OP_NTH) ? (type_match && rank_match)
                                                     : addr_match);
      stat.scan_end = !rd_vld_ff && (rd_ptr_ff >= used_ff);
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      rd_vld_in = rd_go;
      cnt_in = cnt_ff;
      used_in = used_ff;
      if (cmd.load) begin
         rd_ptr_in = '0;
         rd_vld_in = 1'b0;
         cnt_in = '0;
      end else if (cmd.start_shift) begin
         // resume reading just past the deleted entry
         rd_ptr_in = PTR_W'(rd_idx_ff) + PTR_W'(1);
         rd_vld_in = 1'b0;
      end else begin
         if (rd_go) begin
            rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         end
         if (rd_vld_ff && type_match && !cmd.shift_wr) begin
            cnt_in = cnt_ff + PTR_W'(1);
         end
      end
      if (cmd.clear) begin
         used_in = '0;
      end else if (cmd.append) begin
         used_in = used_ff + PTR_W'(1);
      end else if (cmd.shrink) begin
         used_in = used_ff - PTR_W'(1);
      end
   end

   always_comb begin
      rsp_in.status = cmd.status;
      rsp_in.found_type = NOT_FOUND_TYPE;
      rsp_in.found_state = 8'd0;
      rsp_in.found_addr = 16'd0;
      rsp_in.type_count = 7'd0;
      if (cmd.status == ST_OK) begin
         if (item_ff.op == OP_LOOKUP) begin
            rsp_in.found_type = cap_ff.dtype;
            rsp_in.found_state = cap_ff.state;
         end
         if (item_ff.op == OP_NTH) begin
            rsp_in.found_addr = cap_ff.addr;
         end
      end
      if (item_ff.op == OP_COUNT) begin
         rsp_in.type_count = (32'(cnt_ff) > COUNT_MAX) ? 7'(COUNT_MAX) : 7'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         rd_ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         used_ff <= used_in;
         rd_ptr_ff <= rd_ptr_in;
         rd_vld_ff <= rd_vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (rd_go) begin
         rd_idx_ff <= rd_ptr_ff[SLOT_W-1:0];
      end
      if (cmd.capture) begin
         cap_ff <= rd_entry;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PTR_W'(TABLE_SLOTS))
      else $error("entry count beyond table size");
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (used_ff < PTR_W'(TABLE_SLOTS)))
      else $error("append into a full table");
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (PTR_W'(rd_idx_ff) < used_ff))
      else $error("read of a slot outside the occupied range");
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_wr && rd_vld_ff) |-> (rd_idx_ff != '0))
      else $error("shift write below slot zero");
`endif

endmodule

>>> hw/rtl/drt_ctrl.sv
// operation sequencer and handshake control of the device registry table
module drt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  drt_pkg::dp_stat_type stat,
   output drt_pkg::dp_cmd_type  cmd
);
   import drt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.status = status_ff;
      state_in = state_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            case (stat.op)
               OP_ADD: begin
                  cmd.issue = !stat.addr_zero;
                  if (stat.addr_zero || stat.hit) begin
                     status_in = ST_DUPLICATE;
                     state_in = S_FINISH;
                  end else if (stat.scan_end) begin
                     if (stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.append = 1'b1;
                        status_in = ST_OK;
                     end
                     state_in = S_FINISH;
                  end
               end
               OP_DELETE: begin
                  cmd.issue = 1'b1;
                  if (stat.hit) begin
                     cmd.issue = 1'b0;
                     cmd.start_shift = 1'b1;
                     state_in = S_SHIFT;
                  end else if (stat.scan_end) begin
                     status_in = ST_NOT_FOUND;
                     state_in = S_FINISH;
                  end
               end
               OP_LOOKUP, OP_NTH: begin
                  cmd.issue = 1'b1;
                  if (stat.hit) begin
                     cmd.capture = 1'b1;
                     status_in = ST_OK;
                     state_in = S_FINISH;
                  end else if (stat.scan_end) begin
                     status_in = ST_NOT_FOUND;
                     state_in = S_FINISH;
                  end
               end
               OP_COUNT: begin
                  cmd.issue = 1'b1;
                  if (stat.scan_end) begin
                     status_in = ST_OK;
                     state_in = S_FINISH;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  status_in = ST_OK;
                  state_in = S_FINISH;
               end
               default: begin
                  status_in = ST_NOT_FOUND;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SHIFT: begin
            // move each later entry one slot forward
            cmd.issue = 1'b1;
            cmd.shift_wr = 1'b1;
            if (stat.scan_end) begin
               cmd.shrink = 1'b1;
               status_in = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE) && req_valid)
      else $error("transaction loaded outside idle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending response overwritten");
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("response load did not complete the transaction");
`endif

endmodule

>>> hw/rtl/device_registry_table_unit.sv
// top level of the device registry table
// clear, zero-address add and undefined op go from the scan state straight to finish; other
//   ops scan one slot per cycle through the ram read port, and delete stops at the hit then
//   shifts later entries forward; finish raises rsp_valid once the response register is free
// one transaction at a time: req_stall stays high until the response is loaded
// reset clears the entry count and all control state; table contents need no clearing
module device_registry_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drt_pkg::rsp_type rsp_data
);
   import drt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   drt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
